// ===== rtl/dtnp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtnp_pkg
// Shared types, character codes and byte classes of the decimal text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtnp_pkg;

  // width of the fraction digit count (holds up to fifteen digits)
  localparam int FRAC_W = 4;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;
  localparam logic [7:0] ASCII_DOT  = 8'h2e;
  localparam logic [7:0] ASCII_TAB  = 8'h09;
  localparam logic [7:0] ASCII_CR   = 8'h0d;
  localparam logic [7:0] ASCII_SPC  = 8'h20;
  localparam logic [7:0] ASCII_SLSH = 8'h2f;
  localparam logic [7:0] ASCII_COLN = 8'h3a;
  localparam logic [7:0] ASCII_AT   = 8'h40;
  localparam logic [7:0] ASCII_LBRK = 8'h5b;
  localparam logic [7:0] ASCII_BTCK = 8'h60;
  localparam logic [7:0] ASCII_LBRC = 8'h7b;
  localparam logic [7:0] ASCII_TILD = 8'h7e;

  // per-number control state
  typedef struct packed {
    logic [FRAC_W-1:0] frac_cnt;
    logic              started;
    logic              in_frac;
    logic              ovf;
  } dtnp_ctl_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ASCII_ZERO) && (c <= ASCII_NINE);
  endfunction

  // whitespace or punctuation
  function automatic logic is_delim(input logic [7:0] c);
    return ((c >= ASCII_TAB) && (c <= ASCII_CR)) || (c == ASCII_SPC) ||
           ((c >  ASCII_SPC) && (c <= ASCII_SLSH)) ||
           ((c >= ASCII_COLN) && (c <= ASCII_AT)) ||
           ((c >= ASCII_LBRK) && (c <= ASCII_BTCK)) ||
           ((c >= ASCII_LBRC) && (c <= ASCII_TILD));
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dtnp_char_step.sv =====
// ----------------------------------------------------------------------------
// dtnp_char_step
// Next number state for one text byte: digit accumulate, point, delimiter.
// ----------------------------------------------------------------------------
`default_nettype none

module dtnp_char_step
  import dtnp_pkg::*;
#(
  parameter int MANTISSA_BITS = 48,
  parameter int MAX_FRAC      = 9
) (
  input  wire logic [7:0]               text_byte,
  input  wire logic                     end_of_text,
  input  wire logic [MANTISSA_BITS-1:0] acc,
  input  wire dtnp_ctl_t                ctl,
  output logic      [MANTISSA_BITS-1:0] acc_upd,
  output dtnp_ctl_t                     ctl_upd,
  output logic                          emit
);

  localparam int PROD_W = MANTISSA_BITS + 4;

  logic [PROD_W-1:0] acc_wide;
  logic [PROD_W-1:0] prod;
  logic [3:0]        digit;
  logic              fits;
  logic              dig;
  logic              delim;
  logic              enter_frac;
  logic              delim_emit;

  assign digit    = 4'(text_byte - ASCII_ZERO);
  assign acc_wide = PROD_W'(acc);
  // acc * 10 + digit as two shifted terms
  assign prod     = (acc_wide << 3) + (acc_wide << 1) + PROD_W'(digit);
  assign fits     = (prod[PROD_W-1:MANTISSA_BITS] == '0);

  assign dig        = is_digit(text_byte);
  assign delim      = is_delim(text_byte);
  assign enter_frac = (text_byte == ASCII_DOT) && ctl.started && !ctl.in_frac;
  assign delim_emit = delim && !enter_frac && ctl.started;

  always_comb begin
    acc_upd = acc;
    ctl_upd = ctl;
    if (dig) begin
      ctl_upd.started = 1'b1;
      if (!ctl.in_frac) begin
        if (fits) begin
          acc_upd = prod[MANTISSA_BITS-1:0];
        end else begin
          acc_upd     = '1;
          ctl_upd.ovf = 1'b1;
        end
      end else if ((ctl.frac_cnt < FRAC_W'(MAX_FRAC)) && fits) begin
        acc_upd          = prod[MANTISSA_BITS-1:0];
        ctl_upd.frac_cnt = ctl.frac_cnt + 1'b1;
      end else begin
        ctl_upd.ovf = 1'b1;
      end
    end else if (enter_frac) begin
      ctl_upd.in_frac = 1'b1;
    end
  end

  // a delimiter leaves the state alone, so the updated state is what goes out
  assign emit = delim_emit || (end_of_text && ctl_upd.started);

endmodule

`default_nettype wire

// ===== rtl/decimal_text_number_parser.sv =====
// ----------------------------------------------------------------------------
// decimal_text_number_parser
// Pulls unsigned decimal numbers out of an ASCII byte stream as fixed point.
// ----------------------------------------------------------------------------
// One text byte per request on the slave side, one number per request on the
// master side. A byte is taken every cycle while results are being drained;
// each byte passes an input register and one step of accumulate logic (a
// multiply by ten as shift-and-add plus a fit check) into the result
// register, which takes a number from the delimiter, point or last byte
// that ends it. Whitespace and punctuation end a number, the first
// '.' after a digit starts the fraction, other bytes are ignored, and tlast
// flushes a pending number. value = mantissa / 10^fraction_digits. The
// mantissa saturates at all ones on overflow, fraction digits past MAX_FRAC
// are dropped, and either case sets the overflowed flag in tuser.
`default_nettype none

module decimal_text_number_parser
  import dtnp_pkg::*;
#(
  parameter int MANTISSA_BITS = 48,
  parameter int MAX_FRAC      = 9
) (
  input  wire logic clk,
  input  wire logic rst,
  // byte stream
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // text_byte
  input  wire logic       s_axis_tlast,   // end_of_text
  // number stream
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  output logic [((MANTISSA_BITS+FRAC_W+7)/8)*8-1:0]    m_axis_tdata,
  // m_axis_tdata: mantissa, fraction_digits, zero pad
  output logic                                         m_axis_tuser   // overflowed
);

  localparam int TDATA_W = ((MANTISSA_BITS + FRAC_W + 7) / 8) * 8;

  // input register
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;

  // number state
  logic [MANTISSA_BITS-1:0] acc;
  dtnp_ctl_t                ctl;

  // step results
  logic [MANTISSA_BITS-1:0] acc_upd;
  dtnp_ctl_t                ctl_upd;
  logic                     emit;

  // result register
  logic                     out_valid;
  logic [MANTISSA_BITS-1:0] out_mant;
  logic [FRAC_W-1:0]        out_frac;
  logic                     out_ovf;

  logic advance;
  logic accept;

  // the held byte moves on whenever the result register is free or draining
  assign advance       = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  dtnp_char_step #(
    .MANTISSA_BITS(MANTISSA_BITS),
    .MAX_FRAC     (MAX_FRAC)
  ) u_step (
    .text_byte  (in_byte),
    .end_of_text(in_last),
    .acc        (acc),
    .ctl        (ctl),
    .acc_upd    (acc_upd),
    .ctl_upd    (ctl_upd),
    .emit       (emit)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (accept) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // number state, cleared once a number goes out
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      ctl <= '0;
    end else if (in_valid && advance) begin
      if (emit) begin
        acc <= '0;
        ctl <= '0;
      end else begin
        acc <= acc_upd;
        ctl <= ctl_upd;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && emit;
    end
    if (advance && in_valid && emit) begin
      out_mant <= acc_upd;
      out_frac <= ctl_upd.frac_cnt;
      out_ovf  <= ctl_upd.ovf;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = TDATA_W'({out_frac, out_mant});
  assign m_axis_tuser  = out_ovf;

endmodule

`default_nettype wire

// ===== rtl/dtnp_checker.sv =====
// ----------------------------------------------------------------------------
// dtnp_checker
// Port-level checks on the decimal text parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module dtnp_checker
  import dtnp_pkg::*;
#(
  parameter int MANTISSA_BITS = 48,
  parameter int MAX_FRAC      = 9
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic       s_axis_tvalid,
  input wire logic       s_axis_tready,
  input wire logic                                      m_axis_tvalid,
  input wire logic                                      m_axis_tready,
  input wire logic [((MANTISSA_BITS+FRAC_W+7)/8)*8-1:0] m_axis_tdata,
  input wire logic                                      m_axis_tuser
);

  logic s_req;

  assign s_req = s_axis_tvalid && s_axis_tready;

  // a stalled number holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("number changed while stalled");

  // a number after an idle output comes from an accepted byte that went straight through the input register
  a_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_req, 2))
    else $error("number without a matching byte");

  a_frac: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[MANTISSA_BITS +: FRAC_W] <= FRAC_W'(MAX_FRAC))
    else $error("fraction digit count out of range");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata >> (MANTISSA_BITS + FRAC_W)) == '0)
    else $error("tdata pad bits not zero");

endmodule

bind decimal_text_number_parser dtnp_checker #(
  .MANTISSA_BITS(MANTISSA_BITS),
  .MAX_FRAC     (MAX_FRAC)
) u_dtnp_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_decimal_text_number_parser.sv =====
// ----------------------------------------------------------------------------
// tb_decimal_text_number_parser
// Self-checking bench for the decimal text parser: a short table of directed
// bytes, then random text built mostly of well-formed numbers. A predictor
// mirrors the parser per accepted byte and every number the block returns is
// compared field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_decimal_text_number_parser
  import dtnp_pkg::*;
;

  localparam int MANT_W    = 48;
  localparam int FRAC_MAX  = 9;
  localparam int NUM_W     = ((MANT_W + FRAC_W + 7) / 8) * 8;
  localparam int RAND_BYTES = 900;
  localparam logic [63:0] MANT_ALL_ONES = (64'd1 << MANT_W) - 64'd1;
  localparam logic [7:0]  ASCII_COMMA   = 8'h2c;

  typedef struct packed {
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] frac_digits;
    logic              overflowed;
  } number_t;

  // how a directed row gets its expectation
  typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_EMITS} row_kind_t;

  typedef struct {
    logic [7:0] chr;
    logic       last;
    row_kind_t  kind;
    number_t    want;
  } text_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata;   // text_byte
  logic             s_axis_tlast;   // end_of_text
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [NUM_W-1:0] m_axis_tdata;   // mantissa, fraction_digits, zero pad
  logic             m_axis_tuser;   // overflowed

  decimal_text_number_parser #(
    .MANTISSA_BITS(MANT_W),
    .MAX_FRAC     (FRAC_MAX)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor copy of the per-number state
  logic [63:0]       acc_value;
  logic [FRAC_W-1:0] frac_kept;
  logic              num_open;
  logic              frac_mode;
  logic              ovf_flag;

  number_t     pending_numbers[$];
  text_row_t   directed_rows[$];
  logic [7:0]  text_q[$];
  logic        eot_q[$];

  int unsigned cycles;
  int unsigned failures;
  int unsigned bytes_sent;
  int unsigned numbers_checked;
  int unsigned numbers_ovf;
  int unsigned numbers_full_frac;
  int unsigned numbers_sat;

  always @(posedge clk) cycles <= cycles + 1;

  // every so often a stretch where neither side idles
  function automatic logic calm_phase();
    return (cycles % 1024) < 160;
  endfunction

  // idle length: mostly none or short, a few long
  function automatic int pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_phase() || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // true when acc*10+d still fits the mantissa
  function automatic logic fits_ten(input logic [63:0] acc, input logic [63:0] d);
    return acc <= (MANT_ALL_ONES - d) / 64'd10;
  endfunction

  // whitespace 9..13 and 32, punctuation 33..47, 58..64, 91..96, 123..126
  function automatic logic is_separator(input logic [7:0] c);
    return (c >= 8'd9 && c <= 8'd13) || (c >= 8'd32 && c <= 8'd47) ||
           (c >= 8'd58 && c <= 8'd64) || (c >= 8'd91 && c <= 8'd96) ||
           (c >= 8'd123 && c <= 8'd126);
  endfunction

  // queue a number the block owes us
  task automatic expect_number(input number_t n);
    pending_numbers = {pending_numbers, n};
  endtask

  task automatic close_number(output number_t res);
    res.mantissa    = acc_value[MANT_W-1:0];
    res.frac_digits = frac_kept;
    res.overflowed  = ovf_flag;
    acc_value = '0;
    frac_kept = '0;
    num_open  = 1'b0;
    frac_mode = 1'b0;
    ovf_flag  = 1'b0;
  endtask

  // advance the predictor by one byte; at most one number comes out
  task automatic parse_byte(input logic [7:0] c, input logic last,
                            output logic emitted, output number_t res);
    logic [63:0] d;
    emitted = 1'b0;
    res     = '0;
    if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
      d = {56'd0, c - ASCII_ZERO};
      if (!frac_mode) begin
        if (fits_ten(acc_value, d)) begin
          acc_value = acc_value * 64'd10 + d;
        end else begin
          // integer part saturates
          acc_value = MANT_ALL_ONES;
          ovf_flag  = 1'b1;
        end
      end else if (frac_kept < FRAC_MAX && fits_ten(acc_value, d)) begin
        acc_value = acc_value * 64'd10 + d;
        frac_kept = frac_kept + 1'b1;
      end else begin
        // fraction digit dropped
        ovf_flag = 1'b1;
      end
      num_open = 1'b1;
    end else if (is_separator(c)) begin
      if (c == ASCII_DOT && num_open && !frac_mode) begin
        frac_mode = 1'b1;
      end else if (num_open) begin
        close_number(res);
        emitted = 1'b1;
      end
    end
    // flush on end of text; a number closed above leaves nothing here
    if (last && num_open) begin
      close_number(res);
      emitted = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // byte stream driver
  // ---------------------------------------------------------------------------

  // one request on the byte stream; returns the predicted number, if any
  task automatic send_byte(input logic [7:0] c, input logic last,
                           output logic emitted, output number_t res);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    bytes_sent++;
    parse_byte(c, last, emitted, res);
  endtask

  task automatic add_row(input logic [7:0] c, input logic last, input row_kind_t kind,
                         input logic [MANT_W-1:0] mant, input logic [FRAC_W-1:0] frac,
                         input logic ovf);
    text_row_t row;
    row.chr  = c;
    row.last = last;
    row.kind = kind;
    row.want = '{mantissa: mant, frac_digits: frac, overflowed: ovf};
    directed_rows = {directed_rows, row};
  endtask

  function automatic logic [7:0] rand_digit();
    return ASCII_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_separator();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom_range(9, 13));
      1:       return ASCII_SPC;
      2:       return 8'($urandom_range(33, 47));
      3:       return 8'($urandom_range(58, 64));
      4:       return 8'($urandom_range(91, 96));
      default: return 8'($urandom_range(123, 126));
    endcase
  endfunction

  // letters, control codes and the upper half are skipped by the parser
  function automatic logic [7:0] rand_ignored();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(65, 90));
      1:       return 8'($urandom_range(97, 122));
      2:       return 8'($urandom_range(0, 8));
      3:       return 8'($urandom_range(14, 31));
      default: return 8'($urandom_range(127, 255));
    endcase
  endfunction

  task automatic queue_text(input logic [7:0] c, input logic last);
    text_q = {text_q, c};
    eot_q  = {eot_q, last};
  endtask

  // one random chunk: usually a number with its terminator, sometimes noise
  task automatic add_random_chunk();
    int unsigned pick;
    int unsigned int_len;
    int unsigned frac_len;
    logic        has_point;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      queue_text(8'($urandom_range(0, 255)), $urandom_range(0, 11) == 0);
      return;
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) int_len = $urandom_range(1, 5);
    else if (pick < 90) int_len = $urandom_range(6, 14);
    else int_len = $urandom_range(15, 18);
    for (int i = 0; i < int_len; i++) begin
      queue_text(rand_digit(), 1'b0);
      if ($urandom_range(0, 24) == 0) queue_text(rand_ignored(), 1'b0);
    end
    has_point = 1'($urandom_range(0, 1));
    if (has_point) begin
      queue_text(ASCII_DOT, 1'b0);
      frac_len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
      for (int i = 0; i < frac_len; i++) queue_text(rand_digit(), 1'b0);
    end
    case ($urandom_range(0, 9))
      7:       eot_q[eot_q.size()-1] = 1'b1;
      8:       queue_text(has_point ? ASCII_DOT : rand_separator(), 1'b0);
      9:       ;  // runs straight into the next chunk
      default: queue_text(rand_separator(), $urandom_range(0, 11) == 0);
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // number stream: stalls and checking
  // ---------------------------------------------------------------------------

  int unsigned stall_left;

  always @(posedge clk) begin
    int unsigned r;
    if (stall_left > 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      r = $urandom_range(0, 99);
      if (!calm_phase() && r < 25)
        stall_left <= (r < 3) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    end
  end

  always @(posedge clk) begin
    number_t want;
    number_t seen;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.mantissa    = m_axis_tdata[MANT_W-1:0];
      seen.frac_digits = m_axis_tdata[MANT_W+FRAC_W-1:MANT_W];
      seen.overflowed  = m_axis_tuser;
      if (pending_numbers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("[%0t] unexpected number: mant %0d frac %0d ovf %0b", $realtime,
                   seen.mantissa, seen.frac_digits, seen.overflowed);
      end else begin
        want = pending_numbers.pop_front();
        numbers_checked++;
        if (want.overflowed) numbers_ovf++;
        if (want.frac_digits == FRAC_MAX) numbers_full_frac++;
        if (want.mantissa == MANT_ALL_ONES[MANT_W-1:0]) numbers_sat++;
        if (seen.mantissa !== want.mantissa || seen.frac_digits !== want.frac_digits ||
            seen.overflowed !== want.overflowed) begin
          failures++;
          if (failures <= 10)
            $display("[%0t] mismatch: want mant %0d frac %0d ovf %0b, got %0d %0d %0b",
                     $realtime, want.mantissa, want.frac_digits, want.overflowed,
                     seen.mantissa, seen.frac_digits, seen.overflowed);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic    emitted;
    number_t pred;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    acc_value     = '0;
    frac_kept     = '0;
    num_open      = 1'b0;
    frac_mode     = 1'b0;
    ovf_flag      = 1'b0;

    // delimiters with no number open
    add_row(ASCII_SPC, 1'b0, ROW_NONE, '0, '0, 1'b0);
    add_row(ASCII_DOT, 1'b0, ROW_NONE, '0, '0, 1'b0);
    // zero, the smallest mantissa
    add_row(ASCII_ZERO, 1'b0, ROW_PREDICT, '0, '0, 1'b0);
    add_row(ASCII_COMMA, 1'b0, ROW_EMITS, '0, '0, 1'b0);
    // trailing point, then a second point closes the number
    add_row(ASCII_ZERO + 8'd5, 1'b0, ROW_PREDICT, '0, '0, 1'b0);
    add_row(ASCII_DOT, 1'b0, ROW_NONE, '0, '0, 1'b0);
    add_row(ASCII_DOT, 1'b0, ROW_EMITS, 48'd5, '0, 1'b0);
    // byte from the upper half is skipped, even inside a number
    add_row(8'hff, 1'b0, ROW_NONE, '0, '0, 1'b0);
    add_row(ASCII_ZERO + 8'd3, 1'b0, ROW_PREDICT, '0, '0, 1'b0);
    add_row(8'hff, 1'b0, ROW_NONE, '0, '0, 1'b0);
    add_row(ASCII_DOT, 1'b0, ROW_NONE, '0, '0, 1'b0);
    add_row(ASCII_ZERO + 8'd2, 1'b0, ROW_PREDICT, '0, '0, 1'b0);
    // end of text on a digit flushes the number
    add_row(ASCII_ZERO + 8'd7, 1'b1, ROW_EMITS, 48'd327, 4'd2, 1'b0);
    // sixteen nines saturate; a tab with end of text gives just one number
    for (int i = 0; i < 16; i++)
      add_row(ASCII_NINE, 1'b0, ROW_PREDICT, '0, '0, 1'b0);
    add_row(ASCII_TAB, 1'b1, ROW_EMITS, MANT_ALL_ONES[MANT_W-1:0], '0, 1'b1);

    while (text_q.size() < RAND_BYTES) add_random_chunk();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].chr, directed_rows[i].last, emitted, pred);
      case (directed_rows[i].kind)
        ROW_PREDICT: if (emitted) expect_number(pred);
        ROW_EMITS:   expect_number(directed_rows[i].want);
        default:     ;
      endcase
    end

    foreach (text_q[i]) begin
      // hold off once mid-run until the number stream has drained
      if (i == text_q.size() / 2) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_numbers.size() != 0) @(posedge clk);
      end
      send_byte(text_q[i], eot_q[i], emitted, pred);
      if (emitted) expect_number(pred);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_numbers.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("sent %0d text bytes, checked %0d numbers", bytes_sent, numbers_checked);
    $display("%0d numbers flagged overflow, %0d saturated, %0d with a full fraction",
             numbers_ovf, numbers_sat, numbers_full_frac);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d failures", failures);
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d numbers still outstanding", pending_numbers.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
